// ===== sv/sanwc_pkg.sv =====
// Shared constants and types of the set-associative NRU write-back cache.
package sanwc_pkg;

   localparam int ADDR_W = 48;
   localparam int WORD_W = 64;
   localparam int TAG_W = 34;
   localparam int TAG_LSB = 14;
   localparam int SET_LSB = 6;
   localparam int SET_FIELD_W = 8;
   localparam int WORD_LSB = 3;
   localparam int WORDS_PER_LINE = 8;
   localparam int WORD_IDX_W = 3;
   localparam int CMD_W = 3;

   localparam int DEFAULT_NUM_SETS = 256;
   localparam int DEFAULT_NUM_WAYS = 4;

   localparam logic [CMD_W-1:0] CMD_PROBE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_WRITE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FILL       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR_REF  = 3'd5;

   // One way of a set as kept in the tag memory.
   typedef struct packed {
      logic             valid;
      logic             refd;
      logic             dirty;
      logic [TAG_W-1:0] tag;
   } way_entry_type;

endpackage

// ===== sv/set_assoc_nru_writeback_cache.sv =====
// Top level of the set-associative NRU write-back cache.
//
// A set-associative write-back cache with NUM_WAYS ways per set, NUM_SETS sets and lines of
// eight 64-bit words, replacing by NRU (not recently used). Each request transaction carries
// a command: probe, read, write, read-then-write, fill line or clear reference bits. Access
// commands answer with one response transaction after a tag lookup, then a memory update
// and data return. A fill writes the eight words of the line into the data memory, one per
// cycle with a clean victim, and then answers; with a dirty victim it streams the old line
// out as eight response transactions, alternating between writing a word and sending its old
// value, because each word is read from the single data memory port in the same cycle its
// replacement is written. A clear walks the tag memory one set per cycle. The block works
// on one transaction at a time; req_stall is high while a transaction is in progress, and a
// finished response sits in an output register so the next request can be taken while it
// waits. After reset the block invalidates every set of the tag memory and holds req_stall
// high during that sweep.
module set_assoc_nru_writeback_cache #(
   parameter int NUM_SETS = sanwc_pkg::DEFAULT_NUM_SETS,
   parameter int NUM_WAYS = sanwc_pkg::DEFAULT_NUM_WAYS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sanwc_pkg::CMD_W-1:0]         req_cmd,
   input  logic [sanwc_pkg::ADDR_W-1:0]        req_address,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_0,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_1,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_2,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_3,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_4,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_5,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_6,
   input  logic [sanwc_pkg::WORD_W-1:0]        req_line_word_7,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [sanwc_pkg::WORD_W-1:0]        rsp_data_word,
   output logic                                rsp_writeback_needed,
   output logic [sanwc_pkg::ADDR_W-1:0]        rsp_writeback_address,
   output logic [sanwc_pkg::WORD_IDX_W-1:0]    rsp_word_number,
   output logic                                rsp_last
);

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W = $clog2(NUM_WAYS);
   localparam int CNT_W = SET_W + 1;
   localparam int DADDR_W = SET_W + WAY_W + sanwc_pkg::WORD_IDX_W;
   localparam int DATA_DEPTH = 1 << DADDR_W;
   localparam int SET_LUT_N = 1 << sanwc_pkg::SET_FIELD_W;
   localparam logic [sanwc_pkg::WORD_IDX_W-1:0] LAST_WORD =
      sanwc_pkg::WORD_IDX_W'(sanwc_pkg::WORDS_PER_LINE - 1);

   typedef enum logic [5:0] {
      S_INIT = 6'b000001,
      S_IDLE = 6'b000010,
      S_LOOK = 6'b000100,
      S_FILL = 6'b001000,
      S_EMIT = 6'b010000,
      S_CLR  = 6'b100000
   } state_type;

   typedef sanwc_pkg::way_entry_type [NUM_WAYS-1:0] set_row_type;

   // The set field is eight address bits taken modulo the set count; this table folds it.
   logic [SET_W-1:0] set_lut [SET_LUT_N];
   for (genvar i = 0; i < SET_LUT_N; i++) begin : g_set_lut
      assign set_lut[i] = SET_W'(i % NUM_SETS);
   end

   // Memories: one tag row per set, one data word per (set, way, word).
   set_row_type tag_mem [NUM_SETS];
   logic [sanwc_pkg::WORD_W-1:0] data_mem [DATA_DEPTH];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [sanwc_pkg::WORD_IDX_W-1:0] k_ff, k_in;
   logic [sanwc_pkg::CMD_W-1:0] cmd_ff;
   logic [SET_W-1:0] set_ff;
   logic [sanwc_pkg::TAG_W-1:0] tag_ff;
   logic [sanwc_pkg::WORD_IDX_W-1:0] word_ff;
   logic [sanwc_pkg::WORD_W-1:0] line_ff [sanwc_pkg::WORDS_PER_LINE];
   logic [WAY_W-1:0] victim_ff, victim_in;
   logic victim_dirty_ff, victim_dirty_in;
   logic [sanwc_pkg::ADDR_W-1:0] wba_ff, wba_in;
   logic hit_ff, hit_in;
   logic use_rd_ff, use_rd_in;
   logic wb_ff, wb_in;
   logic last_ff, last_in;

   set_row_type tag_rd_ff;
   logic [sanwc_pkg::WORD_W-1:0] data_rd_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff;
   logic [sanwc_pkg::WORD_W-1:0] rsp_data_ff;
   logic rsp_wb_ff;
   logic [sanwc_pkg::ADDR_W-1:0] rsp_wba_ff;
   logic [sanwc_pkg::WORD_IDX_W-1:0] rsp_word_ff;
   logic rsp_last_ff;

   logic req_take, out_free, emit;
   logic tm_we, tm_re;
   logic [SET_W-1:0] tm_wa, tm_ra;
   set_row_type tm_wd;
   logic dm_we, dm_re;
   logic [DADDR_W-1:0] dm_addr;
   logic [sanwc_pkg::WORD_W-1:0] dm_wd;

   logic is_access, is_read, is_write;
   logic hit_any;
   logic [WAY_W-1:0] hit_way, vic_way;
   set_row_type row_upd, row_clr;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit = (state_ff == S_EMIT) && out_free;

   assign is_access = (cmd_ff == sanwc_pkg::CMD_PROBE) || (cmd_ff == sanwc_pkg::CMD_READ) ||
                      (cmd_ff == sanwc_pkg::CMD_WRITE) || (cmd_ff == sanwc_pkg::CMD_READ_WRITE);
   assign is_read = (cmd_ff == sanwc_pkg::CMD_READ) || (cmd_ff == sanwc_pkg::CMD_READ_WRITE);
   assign is_write = (cmd_ff == sanwc_pkg::CMD_WRITE) || (cmd_ff == sanwc_pkg::CMD_READ_WRITE);

   // Tag match and NRU victim choice over the row read for this set. Loops run from the
   // highest way down so the lowest matching way wins.
   always_comb begin
      hit_any = 1'b0;
      hit_way = '0;
      vic_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (tag_rd_ff[w].valid && (tag_rd_ff[w].tag == tag_ff)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      // Class order r0d0, r0d1, r1d0, r1d1, then any invalid way takes precedence.
      for (int c = 3; c >= 0; c--) begin
         for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if ({tag_rd_ff[w].refd, tag_rd_ff[w].dirty} == 2'(c)) begin
               vic_way = WAY_W'(w);
            end
         end
      end
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (!tag_rd_ff[w].valid) begin
            vic_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      row_upd = tag_rd_ff;
      if (is_access) begin
         row_upd[hit_way].refd = 1'b1;
         if (is_write) begin
            row_upd[hit_way].dirty = 1'b1;
         end
      end else begin
         row_upd[vic_way].valid = 1'b1;
         row_upd[vic_way].refd = 1'b0;
         row_upd[vic_way].dirty = 1'b0;
         row_upd[vic_way].tag = tag_ff;
      end
      row_clr = tag_rd_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_clr[w].refd = 1'b0;
      end
   end

   // Sequencer and memory port control.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      victim_in = victim_ff;
      victim_dirty_in = victim_dirty_ff;
      wba_in = wba_ff;
      hit_in = hit_ff;
      use_rd_in = use_rd_ff;
      wb_in = wb_ff;
      last_in = last_ff;
      tm_we = 1'b0;
      tm_re = 1'b0;
      tm_wa = set_ff;
      tm_ra = set_ff;
      tm_wd = row_upd;
      dm_we = 1'b0;
      dm_re = 1'b0;
      dm_addr = {set_ff, hit_way, word_ff};
      dm_wd = line_ff[0];
      unique case (state_ff)
         S_INIT: begin
            // Invalidate one set per cycle after reset.
            tm_we = 1'b1;
            tm_wa = cnt_ff[SET_W-1:0];
            tm_wd = '0;
            if (cnt_ff == CNT_W'(NUM_SETS - 1)) begin
               cnt_in = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            tm_re = req_take;
            tm_ra = set_lut[req_address[sanwc_pkg::SET_LSB +: sanwc_pkg::SET_FIELD_W]];
            if (req_take) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            hit_in = 1'b0;
            use_rd_in = 1'b0;
            wb_in = 1'b0;
            last_in = 1'b1;
            if (is_access) begin
               // Hit: update NRU and dirty state, access the word in the same cycle.
               hit_in = hit_any;
               use_rd_in = hit_any && is_read;
               tm_we = hit_any;
               dm_re = hit_any && is_read;
               dm_we = hit_any && is_write;
               state_in = S_EMIT;
            end else if (cmd_ff == sanwc_pkg::CMD_FILL) begin
               tm_we = 1'b1;
               victim_in = vic_way;
               victim_dirty_in = tag_rd_ff[vic_way].valid && tag_rd_ff[vic_way].dirty;
               wba_in = {tag_rd_ff[vic_way].tag, sanwc_pkg::TAG_LSB'(0)} |
                        (sanwc_pkg::ADDR_W'(set_ff) << sanwc_pkg::SET_LSB);
               k_in = '0;
               state_in = S_FILL;
            end else if (cmd_ff == sanwc_pkg::CMD_CLEAR_REF) begin
               cnt_in = '0;
               state_in = S_CLR;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_FILL: begin
            // Read-first memory: the old word comes out while the new one goes in.
            dm_addr = {set_ff, victim_ff, k_ff};
            dm_wd = line_ff[k_ff];
            dm_we = 1'b1;
            dm_re = victim_dirty_ff;
            hit_in = 1'b0;
            if (victim_dirty_ff) begin
               use_rd_in = 1'b1;
               wb_in = 1'b1;
               last_in = (k_ff == LAST_WORD);
               state_in = S_EMIT;
            end else if (k_ff == LAST_WORD) begin
               use_rd_in = 1'b0;
               wb_in = 1'b0;
               last_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               if (wb_ff && !last_ff) begin
                  k_in = k_ff + 1'b1;
                  state_in = S_FILL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLR: begin
            // Read set n while writing set n-1 back with its reference bits dropped.
            tm_ra = cnt_ff[SET_W-1:0];
            tm_re = (cnt_ff != CNT_W'(NUM_SETS));
            tm_wa = SET_W'(cnt_ff - 1'b1);
            tm_wd = row_clr;
            tm_we = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(NUM_SETS)) begin
               hit_in = 1'b0;
               use_rd_in = 1'b0;
               wb_in = 1'b0;
               last_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      victim_ff <= victim_in;
      victim_dirty_ff <= victim_dirty_in;
      wba_ff <= wba_in;
      hit_ff <= hit_in;
      use_rd_ff <= use_rd_in;
      wb_ff <= wb_in;
      last_ff <= last_in;
      if (req_take) begin
         cmd_ff <= req_cmd;
         set_ff <= set_lut[req_address[sanwc_pkg::SET_LSB +: sanwc_pkg::SET_FIELD_W]];
         tag_ff <= req_address[sanwc_pkg::TAG_LSB +: sanwc_pkg::TAG_W];
         word_ff <= req_address[sanwc_pkg::WORD_LSB +: sanwc_pkg::WORD_IDX_W];
         line_ff[0] <= req_line_word_0;
         line_ff[1] <= req_line_word_1;
         line_ff[2] <= req_line_word_2;
         line_ff[3] <= req_line_word_3;
         line_ff[4] <= req_line_word_4;
         line_ff[5] <= req_line_word_5;
         line_ff[6] <= req_line_word_6;
         line_ff[7] <= req_line_word_7;
      end
      if (emit) begin
         rsp_hit_ff <= hit_ff;
         rsp_data_ff <= use_rd_ff ? data_rd_ff : '0;
         rsp_wb_ff <= wb_ff;
         rsp_wba_ff <= wb_ff ? wba_ff : '0;
         rsp_word_ff <= wb_ff ? k_ff : '0;
         rsp_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tm_we) begin
         tag_mem[tm_wa] <= tm_wd;
      end
      if (tm_re) begin
         tag_rd_ff <= tag_mem[tm_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         data_mem[dm_addr] <= dm_wd;
      end
      if (dm_re) begin
         data_rd_ff <= data_mem[dm_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_data_word = rsp_data_ff;
   assign rsp_writeback_needed = rsp_wb_ff;
   assign rsp_writeback_address = rsp_wba_ff;
   assign rsp_word_number = rsp_word_ff;
   assign rsp_last = rsp_last_ff;

`ifndef ASSERT_OFF
   // An accepted transaction always goes to the tag lookup next.
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_LOOK))
      else $error("accepted transaction did not proceed to tag lookup");

   // A writeback word never claims a hit.
   a_wb_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_writeback_needed) |-> !rsp_hit)
      else $error("writeback response marked as hit");

   // A clean fill steps through the line one word per cycle.
   a_fill_steps: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FILL) && !victim_dirty_ff && (k_ff != LAST_WORD))
      |=> (k_ff == $past(k_ff) + 1'b1))
      else $error("fill word index did not advance");
`endif

endmodule
